>>> hw/rtl/brfo_pkg.sv
package brfo_pkg;

	localparam int DEF_CAPACITY = 15;

	localparam logic REQ_PUT = 1'b0;
	localparam logic REQ_GET = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERWRITE = 2'd1;
	localparam logic [1:0] ST_REFUSED   = 2'd2;

	typedef struct packed {
		logic       req_type;
		logic [7:0] put_byte;
		logic [5:0] get_count;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic [1:0] status;
		logic [5:0] fill_level;
	} rsp_t;

	typedef struct packed {
		logic put;
		logic get;
		logic emit;
		logic last;
		logic refuse;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
	} stat_t;

endpackage

>>> hw/rtl/brfo_ctrl.sv
module brfo_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             req_type,
	input  logic [5:0]       get_count,
	input  brfo_pkg::stat_t  stat,
	output logic             busy,
	output brfo_pkg::cmd_t   cmd
);
	import brfo_pkg::*;

	typedef enum logic {IDLE, GET_RUN} state_t;

	state_t     state_q;
	logic [5:0] remain_q;
	logic       go_run;

	assign busy = (state_q == GET_RUN);

	always_comb begin
		cmd    = '0;
		go_run = 1'b0;
		unique case (state_q)
			IDLE: begin
				if (start) begin
					cmd.emit = 1'b1;
					if (req_type == REQ_PUT) begin
						cmd.put  = 1'b1;
						cmd.last = 1'b1;
					end else if (get_count > stat.fill) begin
						cmd.refuse = 1'b1;
						cmd.last   = 1'b1;
					end else if (get_count == 6'd0) begin
						cmd.last = 1'b1;
					end else begin
						cmd.get  = 1'b1;
						cmd.last = (get_count == 6'd1);
						go_run   = (get_count != 6'd1);
					end
				end
			end
			GET_RUN: begin
				cmd.get  = 1'b1;
				cmd.emit = 1'b1;
				cmd.last = (remain_q == 6'd1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			remain_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (go_run) begin
						state_q  <= GET_RUN;
						remain_q <= get_count - 6'd1;
					end
				end
				GET_RUN: begin
					remain_q <= remain_q - 6'd1;
					if (remain_q == 6'd1) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/brfo_dp.sv
module brfo_dp #(
	parameter int CAPACITY = brfo_pkg::DEF_CAPACITY
) (
	input  logic             clk,
	input  logic             arst_n,
	input  brfo_pkg::cmd_t   cmd,
	input  logic [7:0]       put_byte,
	output brfo_pkg::stat_t  stat,
	output logic             strobe,
	output brfo_pkg::rsp_t   result
);
	import brfo_pkg::*;

	localparam int SLOTS = CAPACITY + 1;
	localparam int PW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [PW-1:0] LAST_SLOT = PW'(SLOTS - 1);
	localparam logic [5:0]    CAP_FILL  = 6'(CAPACITY);

	logic [7:0]    mem [SLOTS];
	logic [PW-1:0] rptr_q;
	logic [PW-1:0] wptr_q;
	logic [5:0]    fill_q;
	logic [7:0]    rd_q;
	logic          last_q;
	logic [1:0]    status_q;
	logic          strobe_q;
	logic          full;
	logic [PW-1:0] rptr_nxt;
	logic [PW-1:0] wptr_nxt;

	assign full     = (fill_q == CAP_FILL);
	assign rptr_nxt = (rptr_q == LAST_SLOT) ? '0 : rptr_q + PW'(1);
	assign wptr_nxt = (wptr_q == LAST_SLOT) ? '0 : wptr_q + PW'(1);

	assign stat.fill = fill_q;
	assign strobe    = strobe_q;

	always_comb begin
		result.out_byte   = rd_q;
		result.last       = last_q;
		result.status     = status_q;
		result.fill_level = fill_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			mem[wptr_q] <= put_byte;
		end
		if (cmd.get) begin
			rd_q <= mem[rptr_q];
		end else begin
			rd_q <= '0;
		end
		last_q <= cmd.last;
		if (cmd.refuse) begin
			status_q <= ST_REFUSED;
		end else if (cmd.put && full) begin
			status_q <= ST_OVERWRITE;
		end else begin
			status_q <= ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q   <= '0;
			wptr_q   <= '0;
			fill_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.put) begin
				wptr_q <= wptr_nxt;
				if (full) begin
					rptr_q <= rptr_nxt;
				end else begin
					fill_q <= fill_q + 6'd1;
				end
			end else if (cmd.get) begin
				rptr_q <= rptr_nxt;
				fill_q <= fill_q - 6'd1;
			end
		end
	end

endmodule

>>> hw/rtl/byte_ring_fifo_overwrite.sv
// Byte ring FIFO, overwrite-oldest on full.
// Request channel: start/busy plus req (type, byte, count). A request is
// transferred on a rising edge with start high and busy low.
// Result channel: strobe marks result for one cycle; there is no back
// pressure, so the receiver must take every result as it appears.
// The first result appears in the cycle after the request transfer.
// Throughput: a put, a refused get and a zero-count get each give a single
// result; a get of N bytes returns one byte per cycle from the single read
// port of the slot memory, with busy high while the bytes after the first are read.
// The next request may be transferred in the cycle that shows the final
// result of the previous one.
// Each result carries the fill level after that result. A put to a full
// FIFO stores the byte, drops the oldest one and reports overwrite. A get
// asking for more bytes than stored is refused and removes nothing.
// Reset clears both pointers and the fill level; slot contents are not
// cleared and are never read before being written.
module byte_ring_fifo_overwrite #(
	parameter int CAPACITY = brfo_pkg::DEF_CAPACITY
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  brfo_pkg::req_t  req,
	output logic            strobe,
	output brfo_pkg::rsp_t  result
);
	import brfo_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	brfo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req.req_type),
		.get_count (req.get_count),
		.stat      (stat),
		.busy      (busy),
		.cmd       (cmd)
	);

	brfo_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.put_byte (req.put_byte),
		.stat     (stat),
		.strobe   (strobe),
		.result   (result)
	);

endmodule

>>> hw/rtl/brfo_chk.sv
module brfo_chk #(
	parameter int CAPACITY = brfo_pkg::DEF_CAPACITY
) (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input brfo_pkg::req_t  req,
	input logic            strobe,
	input brfo_pkg::rsp_t  result
);
	import brfo_pkg::*;

	localparam logic [5:0] CAP_FILL = 6'(CAPACITY);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> result.fill_level <= CAP_FILL)
		else $error("fill level above capacity");

	a_req_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> strobe)
		else $error("transfer without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!start && !busy) |=> !strobe)
		else $error("result without request");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |-> busy)
		else $error("run not finished but idle");

	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.status == ST_REFUSED) |-> (result.last && result.out_byte == 8'd0))
		else $error("refused get malformed");

endmodule

bind byte_ring_fifo_overwrite brfo_chk #(.CAPACITY(CAPACITY)) u_brfo_chk (.*);
